@@ hw/rtl/gate_implication_unit_assert.svh @@
// Assertion macros for the gate implication unit.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef GATE_IMPLICATION_UNIT_ASSERT_SVH
`define GATE_IMPLICATION_UNIT_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define GIU_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define GIU_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

@@ hw/rtl/giu_pkg.sv @@
package giu_pkg;

  localparam int GateKindW = 3;
  localparam int NumIn     = 3;
  localparam int MaskW     = NumIn + 1;
  localparam int OutBit    = NumIn;

  typedef enum logic [GateKindW-1:0] {
    GK_AND2 = 3'd0,
    GK_OR2  = 3'd1,
    GK_XOR2 = 3'd2,
    GK_XOR3 = 3'd3,
    GK_MAJ3 = 3'd4
  } gate_kind_t;

  typedef struct packed {
    logic [GateKindW-1:0] gate_kind;
    logic [NumIn-1:0]     in_known;
    logic [NumIn-1:0]     in_value;
    logic [NumIn-1:0]     in_inverted;
    logic                 gate_out_known;
    logic                 out_value;
  } gate_item_t;

  typedef struct packed {
    logic             conflict;
    logic [MaskW-1:0] imply_mask;
    logic [MaskW-1:0] imply_value;
  } imply_res_t;

endpackage

@@ hw/rtl/giu_if.sv @@
interface giu_in_if import giu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [GateKindW-1:0] gate_kind;
  logic [NumIn-1:0]     in_known;
  logic [NumIn-1:0]     in_value;
  logic [NumIn-1:0]     in_inverted;
  logic                 gate_out_known;
  logic                 out_value;

  modport source (
    output valid, gate_kind, in_known, in_value, in_inverted, gate_out_known, out_value,
    input  ready
  );
  modport sink (
    input  valid, gate_kind, in_known, in_value, in_inverted, gate_out_known, out_value,
    output ready
  );
endinterface

interface giu_out_if import giu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             conflict;
  logic [MaskW-1:0] imply_mask;
  logic [MaskW-1:0] imply_value;

  modport source (
    output valid, conflict, imply_mask, imply_value,
    input  ready
  );
  modport sink (
    input  valid, conflict, imply_mask, imply_value,
    output ready
  );
endinterface

@@ hw/rtl/giu_solver.sv @@
module giu_solver import giu_pkg::*; (
  input  gate_item_t item,
  output imply_res_t res
);

  gate_kind_t       kind;
  logic [NumIn-1:0] k;
  logic [NumIn-1:0] inv;
  logic [NumIn-1:0] lv;
  logic             ko;
  logic             ov;
  logic             f;
  logic             a;
  logic             b;
  logic             o;
  logic             par;
  logic             maj;
  logic [2:0]       cnt_all;
  logic [1:0]       cnt_in;
  logic [1:0]       ones;
  logic             conflict;
  logic [MaskW-1:0] mask;
  logic [MaskW-1:0] lit;

  always_comb begin
    kind = gate_kind_t'(item.gate_kind);
    k    = item.in_known;
    inv  = item.in_inverted;
    ko   = item.gate_out_known;
    ov   = item.out_value & ko;
    // Work on literal values; unknown inputs read as zero.
    lv   = (item.in_value ^ inv) & k;

    f       = (kind == GK_OR2);
    a       = lv[0] ^ f;
    b       = lv[1] ^ f;
    o       = ov ^ f;
    par     = ^{ov, lv};
    cnt_all = {2'b00, k[0]} + {2'b00, k[1]} + {2'b00, k[2]} + {2'b00, ko};
    cnt_in  = {1'b0, k[0]} + {1'b0, k[1]} + {1'b0, k[2]};
    ones    = {1'b0, lv[0]} + {1'b0, lv[1]} + {1'b0, lv[2]};
    maj     = (ones >= 2'd2);

    conflict = 1'b0;
    mask     = '0;
    lit      = '0;

    case (kind)
      GK_AND2, GK_OR2: begin
        // OR is handled as AND with every literal complemented.
        if (k[0] && k[1] && ko) begin
          conflict = (o != (a & b));
        end else if (k[0] && k[1]) begin
          mask[OutBit] = 1'b1;
          lit[OutBit]  = (a & b) ^ f;
        end else if ((k[0] && !a) || (k[1] && !b)) begin
          if (ko) begin
            conflict = o;
          end else begin
            mask[OutBit] = 1'b1;
            lit[OutBit]  = f;
          end
        end else if (ko) begin
          if (o) begin
            mask[0] = !k[0];
            lit[0]  = !f;
            mask[1] = !k[1];
            lit[1]  = !f;
          end else if (k[0]) begin
            mask[1] = 1'b1;
            lit[1]  = f;
          end else if (k[1]) begin
            mask[0] = 1'b1;
            lit[0]  = f;
          end
        end
      end
      GK_XOR2: begin
        if (k[0] && k[1] && ko) begin
          conflict = (ov != (lv[0] ^ lv[1]));
        end else if (k[0] && k[1]) begin
          mask[OutBit] = 1'b1;
          lit[OutBit]  = lv[0] ^ lv[1];
        end else if (k[0] && ko) begin
          mask[1] = 1'b1;
          lit[1]  = lv[0] ^ ov;
        end else if (k[1] && ko) begin
          mask[0] = 1'b1;
          lit[0]  = lv[1] ^ ov;
        end
      end
      GK_XOR3: begin
        if (cnt_all == 3'd4) begin
          conflict = par;
        end else if (cnt_all == 3'd3) begin
          if (!ko) begin
            mask[OutBit] = 1'b1;
            lit[OutBit]  = par;
          end else begin
            mask[NumIn-1:0] = ~k;
            lit[NumIn-1:0]  = {NumIn{par}};
          end
        end
      end
      GK_MAJ3: begin
        if (cnt_in == 2'd3) begin
          if (ko) begin
            conflict = (ov != maj);
          end else begin
            mask[OutBit] = 1'b1;
            lit[OutBit]  = maj;
          end
        end else if (cnt_in == 2'd2) begin
          if (ones != 2'd1) begin
            // Both known inputs agree, so they decide the output.
            if (ko) begin
              conflict = (ov != maj);
            end else begin
              mask[OutBit] = 1'b1;
              lit[OutBit]  = maj;
            end
          end else if (ko) begin
            mask[NumIn-1:0] = ~k;
            lit[NumIn-1:0]  = {NumIn{ov}};
          end
        end else if ((cnt_in == 2'd1) && ko && (ones[0] != ov)) begin
          mask[NumIn-1:0] = ~k;
          lit[NumIn-1:0]  = {NumIn{ov}};
        end
      end
      default: begin
      end
    endcase

    if (conflict) begin
      mask = '0;
    end

    res.conflict    = conflict;
    res.imply_mask  = mask;
    // Input implications go back from literal to variable values.
    res.imply_value = {lit[OutBit], lit[NumIn-1:0] ^ inv} & mask;
  end

endmodule

@@ hw/rtl/gate_implication_unit.sv @@
// Gate implication unit: checks one gate (AND2, OR2, XOR2, XOR3 or majority of
// three) against the current partial assignment and reports a conflict or the
// newly forced variables. One gate is accepted in every cycle while the output
// is not held back by out_ch.ready; its result goes from an input register
// through a single combinational pass into a result register. Both registers
// carry a valid bit, so a stalled result holds only its own stage and an empty
// input stage still takes a new gate.
`include "gate_implication_unit_assert.svh"

module gate_implication_unit import giu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  giu_in_if.sink     in_ch,
  giu_out_if.source  out_ch
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  gate_item_t s1_item_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  imply_res_t out_res_r;
  imply_res_t solve_res;
  logic       s2_ready;
  logic       in_xfer;
  logic       s1_adv;

  assign s2_ready = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s2_ready;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign s1_adv = s1_valid_r && s2_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ch.ready) begin
      s1_valid_nxt = in_ch.valid;
    end
    out_valid_nxt = out_valid_r;
    if (s2_ready) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.gate_kind      <= in_ch.gate_kind;
      s1_item_r.in_known       <= in_ch.in_known;
      s1_item_r.in_value       <= in_ch.in_value;
      s1_item_r.in_inverted    <= in_ch.in_inverted;
      s1_item_r.gate_out_known <= in_ch.gate_out_known;
      s1_item_r.out_value      <= in_ch.out_value;
    end
    if (s1_adv) begin
      out_res_r <= solve_res;
    end
  end

  giu_solver u_solver (
    .item (s1_item_r),
    .res  (solve_res)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.conflict    = out_res_r.conflict;
  assign out_ch.imply_mask  = out_res_r.imply_mask;
  assign out_ch.imply_value = out_res_r.imply_value;

  `GIU_ASSERT_NEXT(a_in_lands, in_xfer, s1_valid_r, "accepted gate did not reach the input stage")
  `GIU_ASSERT_NEXT(a_s1_moves, s1_adv, out_valid_r, "input stage advanced without a result")
  `GIU_ASSERT_SAME(a_value_in_mask, out_valid_r, (out_res_r.imply_value & ~out_res_r.imply_mask) == '0, "implied value outside mask")
  `GIU_ASSERT_SAME(a_conflict_clean, out_valid_r && out_res_r.conflict, out_res_r.imply_mask == '0, "conflict with implications")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench import giu_pkg::*; ();

  typedef enum int {
    PH_DIRECTED,
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH,
    PH_HOLD
  } phase_t;

  localparam int ResetCycles    = 9;
  localparam int HoldCycles     = 64;
  localparam int SettleCycles   = 8;
  localparam int WatchdogLimit  = 2000;
  localparam int KindCount      = 1 << GateKindW;

  logic clk;
  logic rst_n;

  giu_in_if  in_ch ();
  giu_out_if out_ch ();

  gate_implication_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gate_item_t pending_gates[$];
  imply_res_t expected_results[$];
  gate_item_t offered_gate;
  imply_res_t want_res;

  phase_t phase          = PH_DIRECTED;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     hold_left      = 0;
  bit     hold_done      = 1'b0;
  int     quiet_cycles   = 0;

  int fail_count     = 0;
  int gates_sent     = 0;
  int directed_count = 0;
  int results_seen   = 0;
  int conflicts_seen = 0;
  int implied_seen   = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Constraint propagation for one gate, worked out on literal values.
  function automatic imply_res_t predict_implication(gate_item_t g);
    logic [NumIn-1:0] known;
    logic [NumIn-1:0] inv;
    logic [NumIn-1:0] lit;
    logic [MaskW-1:0] mask;
    logic [MaskW-1:0] val;
    logic             ko, ov, f, a, b, o, par, maj, conf;
    int               cnt, ones;
    imply_res_t       r;
    known = g.in_known;
    inv   = g.in_inverted;
    ko    = g.gate_out_known;
    ov    = g.out_value & ko;
    lit   = (g.in_value ^ inv) & known;
    conf  = 1'b0;
    mask  = '0;
    val   = '0;
    // OR is handled as AND with every literal complemented.
    f = (g.gate_kind == GK_OR2);
    a = lit[0] ^ f;
    b = lit[1] ^ f;
    o = ov ^ f;
    case (g.gate_kind)
      GK_AND2, GK_OR2: begin
        if (known[0] && known[1] && ko) begin
          conf = (o != (a & b));
        end else if (known[0] && known[1]) begin
          mask[OutBit] = 1'b1;
          val[OutBit]  = (a & b) ^ f;
        end else if ((known[0] && !a) || (known[1] && !b)) begin
          // A controlling input checks an output that is already assigned, else forces it.
          if (ko) begin
            conf = o;
          end else begin
            mask[OutBit] = 1'b1;
            val[OutBit]  = f;
          end
        end else if (ko) begin
          if (o) begin
            for (int i = 0; i < 2; i++) begin
              if (!known[i]) begin
                mask[i] = 1'b1;
                val[i]  = ~f ^ inv[i];
              end
            end
          end else if (known[0]) begin
            mask[1] = 1'b1;
            val[1]  = f ^ inv[1];
          end else if (known[1]) begin
            mask[0] = 1'b1;
            val[0]  = f ^ inv[0];
          end
        end
      end
      GK_XOR2: begin
        if (known[0] && known[1] && ko) begin
          conf = (ov != (lit[0] ^ lit[1]));
        end else if (known[0] && known[1]) begin
          mask[OutBit] = 1'b1;
          val[OutBit]  = lit[0] ^ lit[1];
        end else if (known[0] && ko) begin
          mask[1] = 1'b1;
          val[1]  = lit[0] ^ ov ^ inv[1];
        end else if (known[1] && ko) begin
          mask[0] = 1'b1;
          val[0]  = lit[1] ^ ov ^ inv[0];
        end
      end
      GK_XOR3: begin
        par = (^lit) ^ ov;
        cnt = $countones({ko, known});
        if (cnt == 4) begin
          conf = par;
        end else if (cnt == 3) begin
          if (!ko) begin
            mask[OutBit] = 1'b1;
            val[OutBit]  = par;
          end else begin
            for (int i = 0; i < NumIn; i++) begin
              if (!known[i]) begin
                mask[i] = 1'b1;
                val[i]  = par ^ inv[i];
              end
            end
          end
        end
      end
      GK_MAJ3: begin
        cnt  = $countones(known);
        ones = $countones(lit);
        if (cnt == 3 || (cnt == 2 && ones != 1)) begin
          // The known inputs already decide the majority.
          maj = (ones >= 2);
          if (ko) begin
            conf = (ov != maj);
          end else begin
            mask[OutBit] = 1'b1;
            val[OutBit]  = maj;
          end
        end else if (ko && (cnt == 2 || (cnt == 1 && ones != int'(ov)))) begin
          for (int i = 0; i < NumIn; i++) begin
            if (!known[i]) begin
              mask[i] = 1'b1;
              val[i]  = ov ^ inv[i];
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (conf) begin
      mask = '0;
      val  = '0;
    end
    r.conflict    = conf;
    r.imply_mask  = mask;
    r.imply_value = val & mask;
    return r;
  endfunction

  function automatic gate_item_t make_gate(logic [GateKindW-1:0] kind, logic [NumIn-1:0] known,
                                           logic [NumIn-1:0] value, logic [NumIn-1:0] inverted,
                                           logic ko, logic ov);
    gate_item_t g;
    g.gate_kind      = kind;
    g.in_known       = known;
    g.in_value       = value;
    g.in_inverted    = inverted;
    g.gate_out_known = ko;
    g.out_value      = ov;
    return g;
  endfunction

  function automatic void enqueue_gate(gate_item_t g);
    pending_gates = {pending_gates, g};
  endfunction

  // Sender: offers the next pending gate, or idles, once the current transfer is done.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results = {expected_results, predict_implication(offered_gate)};
        gates_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_gates.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          offered_gate = pending_gates.pop_front();
          in_ch.valid          <= 1'b1;
          in_ch.gate_kind      <= offered_gate.gate_kind;
          in_ch.in_known       <= offered_gate.in_known;
          in_ch.in_value       <= offered_gate.in_value;
          in_ch.in_inverted    <= offered_gate.in_inverted;
          in_ch.gate_out_known <= offered_gate.gate_out_known;
          in_ch.out_value      <= offered_gate.out_value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer and decides the next ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no gate outstanding");
          fail_count++;
        end else begin
          want_res = expected_results.pop_front();
          if (want_res.conflict) conflicts_seen++;
          if (want_res.imply_mask != '0) implied_seen++;
          if (out_ch.conflict !== want_res.conflict) begin
            $error("conflict: expected %0b, got %0b", want_res.conflict, out_ch.conflict);
            fail_count++;
          end
          if (out_ch.imply_mask !== want_res.imply_mask) begin
            $error("imply_mask: expected %b, got %b", want_res.imply_mask, out_ch.imply_mask);
            fail_count++;
          end
          if (out_ch.imply_value !== want_res.imply_value) begin
            $error("imply_value: expected %b, got %b", want_res.imply_value,
                   out_ch.imply_value);
            fail_count++;
          end
        end
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (phase == PH_HOLD && !hold_done) begin
        // One long hold-off so that the pipeline fills and back-pressures the sender.
        out_ch.ready <= 1'b0;
        hold_left    <= HoldCycles - 1;
        hold_done    <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Sampled between edges so that the sender and receiver have settled.
  task automatic wait_drained();
    while (pending_gates.size() != 0 || in_ch.valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_random_phase(phase_t p, int send_pct, int recv_pct, int count);
    gate_item_t g;
    @(negedge clk);
    phase          <= p;
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
    for (int n = 0; n < count; n++) begin
      // Mostly real gate kinds; the spare encodings turn up now and then.
      if ($urandom_range(99, 0) < 85) begin
        g.gate_kind = GateKindW'($urandom_range(int'(GK_MAJ3), int'(GK_AND2)));
      end else begin
        g.gate_kind = GateKindW'($urandom_range(KindCount - 1, 0));
      end
      g.in_known       = NumIn'($urandom());
      g.in_value       = NumIn'($urandom());
      g.in_inverted    = NumIn'($urandom());
      g.gate_out_known = 1'($urandom_range(1, 0));
      g.out_value      = 1'($urandom_range(1, 0));
      enqueue_gate(g);
    end
    // The sender runs dry here and waits for every result before the next phase.
    wait_drained();
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.gate_kind      = '0;
    in_ch.in_known       = '0;
    in_ch.in_value       = '0;
    in_ch.in_inverted    = '0;
    in_ch.gate_out_known = 1'b0;
    in_ch.out_value      = 1'b0;
    out_ch.ready         = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    // Extremes of every field, each gate kind, and the awkward corners.
    enqueue_gate(make_gate(GK_AND2, 3'b000, 3'b000, 3'b000, 1'b0, 1'b0));
    enqueue_gate(make_gate(GK_AND2, 3'b111, 3'b111, 3'b111, 1'b1, 1'b1));
    enqueue_gate(make_gate(GK_AND2, 3'b001, 3'b000, 3'b000, 1'b1, 1'b1));
    enqueue_gate(make_gate(GK_AND2, 3'b001, 3'b000, 3'b000, 1'b1, 1'b0));
    enqueue_gate(make_gate(GK_AND2, 3'b000, 3'b000, 3'b011, 1'b1, 1'b1));
    enqueue_gate(make_gate(GK_AND2, 3'b000, 3'b111, 3'b000, 1'b0, 1'b1));
    enqueue_gate(make_gate(GK_AND2, 3'b110, 3'b010, 3'b100, 1'b1, 1'b0));
    enqueue_gate(make_gate(GK_OR2, 3'b010, 3'b010, 3'b000, 1'b0, 1'b0));
    enqueue_gate(make_gate(GK_OR2, 3'b001, 3'b000, 3'b000, 1'b1, 1'b0));
    enqueue_gate(make_gate(GK_OR2, 3'b001, 3'b001, 3'b000, 1'b1, 1'b0));
    enqueue_gate(make_gate(GK_XOR2, 3'b001, 3'b001, 3'b110, 1'b1, 1'b0));
    enqueue_gate(make_gate(GK_XOR2, 3'b111, 3'b101, 3'b100, 1'b0, 1'b0));
    enqueue_gate(make_gate(GK_XOR3, 3'b111, 3'b011, 3'b001, 1'b0, 1'b0));
    enqueue_gate(make_gate(GK_XOR3, 3'b101, 3'b100, 3'b010, 1'b1, 1'b1));
    enqueue_gate(make_gate(GK_XOR3, 3'b111, 3'b111, 3'b000, 1'b1, 1'b0));
    enqueue_gate(make_gate(GK_MAJ3, 3'b111, 3'b110, 3'b001, 1'b0, 1'b0));
    enqueue_gate(make_gate(GK_MAJ3, 3'b011, 3'b011, 3'b000, 1'b1, 1'b0));
    enqueue_gate(make_gate(GK_MAJ3, 3'b011, 3'b001, 3'b100, 1'b1, 1'b1));
    enqueue_gate(make_gate(GK_MAJ3, 3'b001, 3'b000, 3'b010, 1'b1, 1'b1));
    enqueue_gate(make_gate(GK_MAJ3, 3'b000, 3'b111, 3'b111, 1'b0, 1'b1));
    for (int kind = int'(GK_MAJ3) + 1; kind < KindCount; kind++) begin
      enqueue_gate(make_gate(GateKindW'(kind), 3'b111, 3'b111, 3'b111, 1'b1, 1'b1));
    end
    directed_count = pending_gates.size();
    wait_drained();

    run_random_phase(PH_FREE, 0, 0, 400);
    run_random_phase(PH_SEND_IDLE, 70, 0, 400);
    run_random_phase(PH_RECV_STALL, 0, 70, 400);
    run_random_phase(PH_BOTH, 30, 30, 500);
    run_random_phase(PH_HOLD, 0, 0, 100);

    repeat (SettleCycles) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    $display("Checked %0d gates (%0d directed) across idle, stall and back-pressure phases.",
             gates_sent, directed_count);
    $display("Results: %0d received, %0d conflicts, %0d carrying implications, %0d errors.",
             results_seen, conflicts_seen, implied_seen, fail_count);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/giu_pkg.sv
hw/rtl/giu_if.sv
hw/rtl/giu_solver.sv
hw/rtl/gate_implication_unit.sv
test/testbench.sv
